// ----- rtl/qrm_pkg.sv -----
// ----------------------------------------------------------------------------
// qrm_pkg: shared types and constants of the quaternion to rotation matrix unit
// Payload structs of the two channels and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package qrm_pkg;

  // Width of one component and of one matrix entry.
  localparam int unsigned COMP_W = 32;
  // Width of a product of two components and of the squared length.
  localparam int unsigned PROD_W = 64;
  // Number of matrix entries.
  localparam int unsigned ENTRIES = 9;
  // Entries on the diagonal (0, 4 and 8) take the form 1 - 2N/s.
  localparam logic [ENTRIES-1:0] DIAG_MASK = 9'b100010001;
  // Most negative component code and the value that replaces it.
  localparam logic [COMP_W-1:0] COMP_MIN  = 32'h8000_0000;
  localparam logic [COMP_W-1:0] COMP_CLMP = 32'h8000_0001;

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] m00;
    logic signed [COMP_W-1:0] m01;
    logic signed [COMP_W-1:0] m02;
    logic signed [COMP_W-1:0] m10;
    logic signed [COMP_W-1:0] m11;
    logic signed [COMP_W-1:0] m12;
    logic signed [COMP_W-1:0] m20;
    logic signed [COMP_W-1:0] m21;
    logic signed [COMP_W-1:0] m22;
    logic                     zero_length;
  } matrix_t;

endpackage

// ----- rtl/qrm_if.sv -----
// ----------------------------------------------------------------------------
// qrm_if: valid/ready channels of the quaternion to rotation matrix unit
// One interface for the quaternion input and one for the matrix output.
// ----------------------------------------------------------------------------
interface qrm_quat_if;
  logic          valid;
  logic          ready;
  qrm_pkg::quat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface qrm_matrix_if;
  logic            valid;
  logic            ready;
  qrm_pkg::matrix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/quaternion_to_rotation_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit: normalized quaternion to 3x3 matrix
// Throughput: one quaternion per cycle while the output is not stalled; the restoring
// divider has one stage per quotient bit (FRAC_BITS + 2 stages), nine lanes side by side.
// A stall at the output holds every stage in place.
// Reset (rst, synchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit #(
  parameter int FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  qrm_quat_if.sink     quat,
  qrm_matrix_if.source rot
);

  localparam int QW = FRAC_BITS + 2;   // quotient bits
  localparam int D  = QW;              // divider stages
  localparam int PW = qrm_pkg::PROD_W;
  localparam int CW = qrm_pkg::COMP_W;
  localparam int NE = qrm_pkg::ENTRIES;
  localparam int EW = FRAC_BITS + 4;   // signed width of a finished entry

  // The whole pipeline moves when the output register is free or is taken.
  logic adv;
  assign adv = !rot.valid || rot.ready;
  assign quat.ready = adv;

  // Stage 1: register components, most negative code replaced.
  logic                 st1_valid;
  logic signed [CW-1:0] st1_x, st1_y, st1_z, st1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (adv) begin
      st1_valid <= quat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_x <= (quat.data.quat_x == qrm_pkg::COMP_MIN) ? qrm_pkg::COMP_CLMP : quat.data.quat_x;
      st1_y <= (quat.data.quat_y == qrm_pkg::COMP_MIN) ? qrm_pkg::COMP_CLMP : quat.data.quat_y;
      st1_z <= (quat.data.quat_z == qrm_pkg::COMP_MIN) ? qrm_pkg::COMP_CLMP : quat.data.quat_z;
      st1_w <= (quat.data.quat_w == qrm_pkg::COMP_MIN) ? qrm_pkg::COMP_CLMP : quat.data.quat_w;
    end
  end

  // Stage 2: the ten products, one 32 by 32 multiplier each.
  logic                 st2_valid;
  logic signed [PW-1:0] st2_xx, st2_yy, st2_zz, st2_ww;
  logic signed [PW-1:0] st2_xy, st2_xz, st2_xw, st2_yz, st2_yw, st2_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (adv) begin
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st2_xx <= st1_x * st1_x;
      st2_yy <= st1_y * st1_y;
      st2_zz <= st1_z * st1_z;
      st2_ww <= st1_w * st1_w;
      st2_xy <= st1_x * st1_y;
      st2_xz <= st1_x * st1_z;
      st2_xw <= st1_x * st1_w;
      st2_yz <= st1_y * st1_z;
      st2_yw <= st1_y * st1_w;
      st2_wz <= st1_w * st1_z;
    end
  end

  // Stage 3: squared length and the nine signed numerators.
  logic                 st3_valid;
  logic        [PW-1:0] st3_s;
  logic signed [PW-1:0] st3_num [NE];

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_valid <= 1'b0;
    end else if (adv) begin
      st3_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st3_s      <= PW'(st2_xx) + PW'(st2_yy) + PW'(st2_zz) + PW'(st2_ww);
      st3_num[0] <= st2_yy + st2_zz;
      st3_num[1] <= st2_xy - st2_wz;
      st3_num[2] <= st2_xz + st2_yw;
      st3_num[3] <= st2_xy + st2_wz;
      st3_num[4] <= st2_xx + st2_zz;
      st3_num[5] <= st2_yz - st2_xw;
      st3_num[6] <= st2_xz - st2_yw;
      st3_num[7] <= st2_yz + st2_xw;
      st3_num[8] <= st2_xx + st2_yy;
    end
  end

  // Divider pipeline. Index 0 is stage 4 (magnitudes and signs); index k is
  // the register after quotient bit k. Every numerator is at most s, so the
  // first step compares without a shift and yields the bit of weight 2^(F+1).
  logic          div_valid [D+1];
  logic          div_zero  [D+1];
  logic [PW-1:0] div_s     [D+1];
  logic [PW-1:0] div_rem   [D+1][NE];
  logic [QW-1:0] div_quo   [D+1][NE];
  logic [NE-1:0] div_neg   [D+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (adv) begin
      div_valid[0] <= st3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_s[0]    <= st3_s;
      div_zero[0] <= (st3_s == '0);
      for (int e = 0; e < NE; e++) begin
        div_neg[0][e] <= st3_num[e][PW-1];
        div_rem[0][e] <= st3_num[e][PW-1] ? PW'(-st3_num[e]) : PW'(st3_num[e]);
        div_quo[0][e] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= D; k++) begin : g_div
    localparam bit FIRST = (k == 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[k] <= 1'b0;
      end else if (adv) begin
        div_valid[k] <= div_valid[k-1];
      end
    end

    // One restoring step in each lane: shift, compare with s, subtract.
    always_ff @(posedge clk) begin
      logic [PW:0] trial;
      if (adv) begin
        div_s[k]    <= div_s[k-1];
        div_zero[k] <= div_zero[k-1];
        div_neg[k]  <= div_neg[k-1];
        for (int e = 0; e < NE; e++) begin
          trial = FIRST ? {1'b0, div_rem[k-1][e]} : {div_rem[k-1][e], 1'b0};
          if (trial >= {1'b0, div_s[k-1]}) begin
            div_rem[k][e] <= PW'(trial - {1'b0, div_s[k-1]});
            div_quo[k][e] <= {div_quo[k-1][e][QW-2:0], 1'b1};
          end else begin
            div_rem[k][e] <= PW'(trial);
            div_quo[k][e] <= {div_quo[k-1][e][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Final stage: round to nearest (ties up), apply sign or form 1 - Q, and
  // substitute the identity for a zero-length quaternion. Entries stay in
  // [-2^F, 2^F], so the 32-bit result never needs clamping.
  logic signed [EW-1:0] ent [NE];
  logic signed [EW-1:0] one_q;

  assign one_q = EW'(1) <<< FRAC_BITS;

  always_comb begin
    logic signed [EW-1:0] qr;
    for (int e = 0; e < NE; e++) begin
      qr = EW'(div_quo[D][e]) +
           EW'({div_rem[D][e], 1'b0} >= {1'b0, div_s[D]});
      if (div_zero[D]) begin
        ent[e] = qrm_pkg::DIAG_MASK[e] ? one_q : '0;
      end else if (qrm_pkg::DIAG_MASK[e]) begin
        ent[e] = one_q - qr;
      end else begin
        ent[e] = div_neg[D][e] ? -qr : qr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.valid <= 1'b0;
    end else if (adv) begin
      rot.valid <= div_valid[D];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot.data.m00         <= CW'(ent[0]);
      rot.data.m01         <= CW'(ent[1]);
      rot.data.m02         <= CW'(ent[2]);
      rot.data.m10         <= CW'(ent[3]);
      rot.data.m11         <= CW'(ent[4]);
      rot.data.m12         <= CW'(ent[5]);
      rot.data.m20         <= CW'(ent[6]);
      rot.data.m21         <= CW'(ent[7]);
      rot.data.m22         <= CW'(ent[8]);
      rot.data.zero_length <= div_zero[D];
    end
  end

  // A zero-length result carries the identity on the diagonal.
  a_zero_diag: assert property (@(posedge clk) disable iff (rst)
    rot.valid && rot.data.zero_length |->
      rot.data.m00 == CW'(one_q) && rot.data.m11 == CW'(one_q) &&
      rot.data.m22 == CW'(one_q))
    else $error("identity diagonal missing on zero-length result");

  // A zero-length result has all off-diagonal entries cleared.
  a_zero_cross: assert property (@(posedge clk) disable iff (rst)
    rot.valid && rot.data.zero_length |->
      rot.data.m01 == '0 && rot.data.m02 == '0 && rot.data.m10 == '0 &&
      rot.data.m12 == '0 && rot.data.m20 == '0 && rot.data.m21 == '0)
    else $error("off-diagonal entry set on zero-length result");

  // An accepted transfer occupies the first stage in the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.ready |=> st1_valid)
    else $error("accepted quaternion lost at pipeline entry");

  // In the first cycle after reset no result is offered.
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !rot.valid)
    else $error("result offered straight after reset");

endmodule
